// ===== rtl/core/bba_pkg.sv =====
// Shared types and constants for the buddy block allocator.
// Used by bba_ctrl, bba_dp and buddy_block_allocator; depends on nothing.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int LOG_MAX_BLOCKS_DEF = 10;

  localparam logic [5:0] MIN_ORDER_FLOOR = 6'd5;
  localparam logic [5:0] POOL_ORDER_RST  = 6'd15;
  localparam logic [5:0] MIN_ORDER_RST   = 6'd5;

  localparam logic [1:0] CFG_BASE = 2'd0;
  localparam logic [1:0] CFG_POOL = 2'd1;
  localparam logic [1:0] CFG_MIN  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_NO_FIT   = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_A_LVL, S_A_CHK, S_A_CMP, S_SPLIT, S_PUSH0,
    S_PUSH1, S_A_FIN, S_F_CHK, S_F_TAG, S_F_TST, S_M0, S_M1, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_CLEAR, OP_IDLE, OP_CHECK, OP_A_LVL, OP_A_CHK, OP_A_CMP, OP_SPLIT,
    OP_PUSH0, OP_PUSH1, OP_A_FIN, OP_F_CHK, OP_F_TAG, OP_F_TST, OP_M0,
    OP_M1, OP_DONE
  } dp_op_t;

  typedef struct packed {
    logic err;
    logic is_free;
    logic j_over;
    logic cur_nil;
    logic fit;
    logic bad_free;
    logic tag_set;
    logic o_top;
    logic can_merge;
    logic split_done;
    logic clr_done;
  } dp_stat_t;

endpackage

// ===== rtl/core/bba_ctrl.sv =====
// Sequencing state machine of the buddy block allocator.
// Depends on bba_pkg; drives the operation code of bba_dp.
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             cfg_wr,
  input  bba_pkg::dp_stat_t stat,
  output logic             busy,
  output logic             done,
  output bba_pkg::dp_op_t  op
);
  import bba_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_IDLE;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        op   = OP_IDLE;
        busy = 1'b0;
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        op = OP_CHECK;
        if (stat.err) state_next = S_DONE;
        else if (stat.is_free) state_next = S_F_CHK;
        else state_next = S_A_LVL;
      end
      S_A_LVL: begin
        op = OP_A_LVL;
        state_next = stat.j_over ? S_DONE : S_A_CHK;
      end
      S_A_CHK: begin
        op = OP_A_CHK;
        state_next = stat.cur_nil ? S_A_LVL : S_A_CMP;
      end
      S_A_CMP: begin
        op = OP_A_CMP;
        state_next = stat.fit ? S_SPLIT : S_A_CHK;
      end
      S_SPLIT: begin
        op = OP_SPLIT;
        state_next = stat.split_done ? S_A_FIN : S_PUSH0;
      end
      S_PUSH0: begin
        op = OP_PUSH0;
        state_next = S_PUSH1;
      end
      S_PUSH1: begin
        op = OP_PUSH1;
        state_next = stat.is_free ? S_DONE : S_SPLIT;
      end
      S_A_FIN: begin
        op = OP_A_FIN;
        state_next = S_DONE;
      end
      S_F_CHK: begin
        op = OP_F_CHK;
        state_next = stat.bad_free ? S_DONE : S_F_TAG;
      end
      S_F_TAG: begin
        op = OP_F_TAG;
        state_next = S_F_TST;
      end
      S_F_TST: begin
        op = OP_F_TST;
        state_next = stat.tag_set ? S_DONE : S_M0;
      end
      S_M0: begin
        op = OP_M0;
        state_next = stat.o_top ? S_PUSH0 : S_M1;
      end
      S_M1: begin
        op = OP_M1;
        state_next = stat.can_merge ? S_M0 : S_PUSH0;
      end
      S_DONE: begin
        op   = OP_DONE;
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe lasted more than one cycle");
  a_clear_after_reset: assert property (@(posedge clk) $fell(rst) |-> busy)
    else $error("block not busy clearing after reset");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !cfg_wr) |=> (state == S_CHECK))
    else $error("accepted command did not start processing");

endmodule

// ===== rtl/core/bba_dp.sv =====
// Datapath of the buddy block allocator: configuration, free-list memories,
// list heads and address arithmetic. Depends on bba_pkg; driven by bba_ctrl.
`timescale 1ns / 1ps

module bba_dp #(
  parameter int LOG_MAX_BLOCKS = bba_pkg::LOG_MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bba_pkg::dp_op_t   op,
  input  logic              cfg_valid,
  input  logic              cfg_wr,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              cmd,
  input  logic [5:0]        req_order,
  input  logic [63:0]       free_address,
  input  logic [63:0]       lower_bound,
  input  logic [63:0]       upper_bound,
  output bba_pkg::dp_stat_t stat,
  output logic [1:0]        status,
  output logic [63:0]       block_address,
  output logic [5:0]        granted_order
);
  import bba_pkg::*;

  localparam int NBLK = 1 << LOG_MAX_BLOCKS;
  localparam int NLVL = LOG_MAX_BLOCKS + 1;
  localparam int IW   = LOG_MAX_BLOCKS + 1;
  localparam int LW   = $clog2(NLVL);
  localparam logic [IW-1:0] NIL = IW'(NBLK);

  // Configuration.
  logic [63:0] base_r;
  logic [5:0]  pool_r, min_r;

  // Latched command.
  logic        cmd_r;
  logic [5:0]  ro_r;
  logic [63:0] faddr_r, lb_r, ub_r;

  // Working registers.
  logic [5:0]  emin_r, ord_r, k_r, o_r, p_ord;
  logic [63:0] size_r, off_r, start_r, addr_r;
  logic [6:0]  j_r;
  logic [IW-1:0] cur_r, found_r, idx_r, p_idx, h_r;
  logic [LOG_MAX_BLOCKS-1:0] clr_cnt;
  status_t     status_r;

  logic [IW-1:0] head [NLVL];

  logic          tag_mem  [NBLK];
  logic [5:0]    ordm_mem [NBLK];
  logic [IW-1:0] next_mem [NBLK];
  logic [IW-1:0] prev_mem [NBLK];
  logic          tag_rd;
  logic [5:0]    ordm_rd;
  logic [IW-1:0] next_rd, prev_rd;

  // Combinational.
  logic [5:0]  emin_c, ord_c, km1, ord_diff_k, ord_diff_p, ord_diff_o;
  logic        en_c, too_big;
  logic [6:0]  j_diff;
  logic [LW-1:0] j_lvl, km1_lvl, p_lvl, o_lvl, ul_lvl, head_ra;
  logic [IW-1:0] o_bit, bud_c, ul_idx, head_rd;
  logic [63:0] start_c, pmask, amask;
  logic [64:0] end_c;
  logic        fit, unl;
  logic [LOG_MAX_BLOCKS-1:0] rd_addr;

  logic                      tag_we, ordm_we, next_we, prev_we;
  logic [LOG_MAX_BLOCKS-1:0] tag_wa, ordm_wa, next_wa, prev_wa;
  logic                      tag_wd;
  logic [5:0]                ordm_wd;
  logic [IW-1:0]             next_wd, prev_wd;

  always_comb begin
    emin_c  = (min_r < MIN_ORDER_FLOOR) ? MIN_ORDER_FLOOR : min_r;
    ord_c   = (ro_r < emin_c) ? emin_c : ro_r;
    en_c    = (emin_c <= pool_r) && ((pool_r - emin_c) <= 6'(LOG_MAX_BLOCKS));
    too_big = ro_r > pool_r;

    j_diff     = j_r - {1'b0, emin_r};
    j_lvl      = j_diff[LW-1:0];
    km1        = k_r - 6'd1;
    ord_diff_k = km1 - emin_r;
    km1_lvl    = ord_diff_k[LW-1:0];
    ord_diff_p = p_ord - emin_r;
    p_lvl      = ord_diff_p[LW-1:0];
    ord_diff_o = o_r - emin_r;
    o_lvl      = ord_diff_o[LW-1:0];
    o_bit      = IW'(1) << o_lvl;
    bud_c      = idx_r ^ o_bit;

    head_ra = (op == OP_A_LVL) ? j_lvl : p_lvl;
    head_rd = head[head_ra];

    start_c = base_r + (64'(cur_r) << emin_r);
    end_c   = {1'b0, start_r} + {1'b0, size_r};
    fit     = (start_r >= lb_r) && !end_c[64] && (end_c[63:0] <= ub_r);
    pmask   = ~({64{1'b1}} << pool_r);
    amask   = ~({64{1'b1}} << ord_r);

    stat.err        = too_big || !en_c;
    stat.is_free    = cmd_r;
    stat.j_over     = j_r > {1'b0, pool_r};
    stat.cur_nil    = cur_r == NIL;
    stat.fit        = fit;
    stat.bad_free   = ((off_r & ~pmask) != 64'd0) || ((off_r & amask) != 64'd0);
    stat.tag_set    = tag_rd;
    stat.o_top      = o_r >= pool_r;
    stat.can_merge  = tag_rd && (ordm_rd == o_r);
    stat.split_done = k_r <= ord_r;
    stat.clr_done   = clr_cnt == {LOG_MAX_BLOCKS{1'b1}};

    // Unlinking a block: the found block on allocate, the buddy on free.
    unl    = ((op == OP_A_CMP) && fit) || ((op == OP_M1) && stat.can_merge);
    ul_idx = (op == OP_A_CMP) ? cur_r : bud_c;
    ul_lvl = (op == OP_A_CMP) ? j_lvl : o_lvl;

    case (op)
      OP_F_TAG: rd_addr = idx_r[LOG_MAX_BLOCKS-1:0];
      OP_M0:    rd_addr = bud_c[LOG_MAX_BLOCKS-1:0];
      default:  rd_addr = cur_r[LOG_MAX_BLOCKS-1:0];
    endcase

    tag_we  = 1'b0;
    tag_wa  = ul_idx[LOG_MAX_BLOCKS-1:0];
    tag_wd  = 1'b0;
    ordm_we = 1'b0;
    ordm_wa = p_idx[LOG_MAX_BLOCKS-1:0];
    ordm_wd = p_ord;
    next_we = 1'b0;
    next_wa = prev_rd[LOG_MAX_BLOCKS-1:0];
    next_wd = next_rd;
    prev_we = 1'b0;
    prev_wa = next_rd[LOG_MAX_BLOCKS-1:0];
    prev_wd = prev_rd;
    if (op == OP_CLEAR) begin
      tag_we = 1'b1;
      tag_wa = clr_cnt;
    end
    if (unl) begin
      tag_we  = 1'b1;
      next_we = prev_rd != NIL;
      prev_we = next_rd != NIL;
    end
    if (op == OP_PUSH0) begin
      tag_we  = 1'b1;
      tag_wa  = p_idx[LOG_MAX_BLOCKS-1:0];
      tag_wd  = 1'b1;
      ordm_we = 1'b1;
      next_we = 1'b1;
      next_wa = p_idx[LOG_MAX_BLOCKS-1:0];
      next_wd = head_rd;
      prev_we = 1'b1;
      prev_wa = p_idx[LOG_MAX_BLOCKS-1:0];
      prev_wd = NIL;
    end
    if (op == OP_PUSH1) begin
      prev_we = h_r != NIL;
      prev_wa = h_r[LOG_MAX_BLOCKS-1:0];
      prev_wd = p_idx;
    end
    if (op == OP_A_FIN) begin
      ordm_we = 1'b1;
      ordm_wa = found_r[LOG_MAX_BLOCKS-1:0];
      ordm_wd = ord_r;
    end
  end

  always_ff @(posedge clk) begin
    tag_rd  <= tag_mem[rd_addr];
    ordm_rd <= ordm_mem[rd_addr];
    next_rd <= next_mem[rd_addr];
    prev_rd <= prev_mem[rd_addr];
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    if (ordm_we) ordm_mem[ordm_wa] <= ordm_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_r <= 64'd0;
      pool_r <= POOL_ORDER_RST;
      min_r  <= MIN_ORDER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE: base_r <= cfg_data;
        CFG_POOL: pool_r <= cfg_data[5:0];
        CFG_MIN:  min_r  <= cfg_data[5:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      clr_cnt <= '0;
      for (int i = 0; i < NLVL; i++) head[i] <= NIL;
    end else begin
      if (op == OP_CLEAR) clr_cnt <= clr_cnt + LOG_MAX_BLOCKS'(1);
      if (unl && (prev_rd == NIL)) head[ul_lvl] <= next_rd;
      if (op == OP_PUSH1) head[p_lvl] <= p_idx;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_IDLE: begin
        cmd_r   <= cmd;
        ro_r    <= req_order;
        faddr_r <= free_address;
        lb_r    <= lower_bound;
        ub_r    <= upper_bound;
      end
      OP_CHECK: begin
        emin_r <= emin_c;
        ord_r  <= ord_c;
        size_r <= 64'd1 << ord_c;
        off_r  <= faddr_r - base_r;
        j_r    <= {1'b0, ord_c};
        addr_r <= 64'd0;
        if (too_big) status_r <= ST_TOO_BIG;
        else if (!en_c) status_r <= cmd_r ? ST_BAD_FREE : ST_NO_FIT;
        else status_r <= ST_OK;
      end
      OP_A_LVL: begin
        if (stat.j_over) status_r <= ST_NO_FIT;
        else cur_r <= head_rd;
      end
      OP_A_CHK: begin
        if (stat.cur_nil) j_r <= j_r + 7'd1;
        else start_r <= start_c;
      end
      OP_A_CMP: begin
        if (fit) begin
          found_r <= cur_r;
          k_r     <= j_r[5:0];
        end else begin
          cur_r <= next_rd;
        end
      end
      OP_SPLIT: begin
        if (!stat.split_done) begin
          k_r   <= km1;
          p_ord <= km1;
          p_idx <= found_r + (IW'(1) << km1_lvl);
        end
      end
      OP_PUSH0: h_r <= head_rd;
      OP_A_FIN: addr_r <= start_r;
      OP_F_CHK: begin
        if (stat.bad_free) status_r <= ST_BAD_FREE;
        idx_r <= IW'(off_r >> emin_r);
      end
      OP_F_TST: begin
        if (tag_rd) status_r <= ST_BAD_FREE;
        o_r <= ord_r;
      end
      OP_M0: begin
        if (stat.o_top) begin
          p_idx <= idx_r;
          p_ord <= o_r;
        end
      end
      OP_M1: begin
        if (stat.can_merge) begin
          idx_r <= idx_r & ~o_bit;
          o_r   <= o_r + 6'd1;
        end else begin
          p_idx <= idx_r;
          p_ord <= o_r;
        end
      end
      default: ;
    endcase
  end

  assign status        = status_r;
  assign block_address = addr_r;
  assign granted_order = ord_r;

  a_grant_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (op == OP_A_FIN) |-> (start_r >= lb_r) && (start_r + size_r <= ub_r))
    else $error("granted block lies outside the requested bounds");

endmodule

// ===== rtl/core/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: ties the controller to the datapath.
// Depends on bba_pkg, bba_ctrl and bba_dp.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; its result appears
// for exactly one cycle with done high and cannot be held off. An allocate
// searches the free lists level by level, examining each free entry, and
// then splits the found block down to the granted order; a free checks the
// address and merges the block with its free buddies level by level. After
// reset and after every write to a defined register the block stays busy
// while it clears the free tags; configuration writes are always taken
// (cfg_ready is tied high) and must only be issued while the block is idle.
module buddy_block_allocator #(
  parameter int LOG_MAX_BLOCKS = bba_pkg::LOG_MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [5:0]  req_order,
  input  logic [63:0] free_address,
  input  logic [63:0] lower_bound,
  input  logic [63:0] upper_bound,
  output logic        done,
  output logic [1:0]  status,
  output logic [63:0] block_address,
  output logic [5:0]  granted_order,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import bba_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;
  logic     cfg_wr;

  assign cfg_ready = 1'b1;
  // Only writes to a defined register empty the pool.
  assign cfg_wr = cfg_valid &&
                  (cfg_index == CFG_BASE || cfg_index == CFG_POOL || cfg_index == CFG_MIN);

  bba_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cfg_wr (cfg_wr),
    .stat   (stat),
    .busy   (busy),
    .done   (done),
    .op     (op)
  );

  bba_dp #(
    .LOG_MAX_BLOCKS (LOG_MAX_BLOCKS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .cfg_valid     (cfg_valid),
    .cfg_wr        (cfg_wr),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .req_order     (req_order),
    .free_address  (free_address),
    .lower_bound   (lower_bound),
    .upper_bound   (upper_bound),
    .stat          (stat),
    .status        (status),
    .block_address (block_address),
    .granted_order (granted_order)
  );

endmodule
